// ----- sv/sk64_pkg.sv -----
// Shared constants, types and round functions for the SKINNY-64-64 encrypt core
package sk64_pkg;

  localparam int MAX_ROUNDS  = 32;
  localparam int BLOCK_W     = 64;
  localparam int RK_W        = 32;
  localparam int RC_W        = 6;
  localparam int RCOUNT_W    = 6;
  localparam int CFG_IDX_W   = 2;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [RK_W-1:0]    rkey_t;
  typedef logic [RC_W-1:0]    rconst_t;
  typedef logic [3:0]         cell_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIPHER_KEY  = 2'd0,
    REG_ROUND_COUNT = 2'd1
  } cfg_reg_t;

  localparam logic [RCOUNT_W-1:0] ROUND_COUNT_RST = RCOUNT_W'(MAX_ROUNDS);

  localparam cell_t SBOX [16] = '{
    4'hc, 4'h6, 4'h9, 4'h0, 4'h1, 4'ha, 4'h2, 4'hb,
    4'h3, 4'h8, 4'h5, 4'hd, 4'h4, 4'he, 4'h7, 4'hf
  };

  localparam int TK_PERM [16] = '{9, 15, 8, 13, 10, 14, 12, 11, 0, 1, 2, 3, 4, 5, 6, 7};

  localparam cell_t CELL8_CONST = 4'h2;

  // Round constant for round number rnd (0-based); evaluated at elaboration
  function automatic rconst_t sk64_rc(int rnd);
    rconst_t rc;
    rc = '0;
    for (int i = 0; i <= rnd; i++) begin
      rc = {rc[RC_W-2:0], rc[5] ^ rc[4] ^ 1'b1};
    end
    return rc;
  endfunction

  // Key after rnd applications of the tweakey permutation; evaluated as wiring
  function automatic block_t sk64_key_perm(block_t key, int rnd);
    block_t k;
    block_t nk;
    k = key;
    for (int r = 0; r < rnd; r++) begin
      for (int i = 0; i < 16; i++) begin
        nk[BLOCK_W-1-4*i -: 4] = k[BLOCK_W-1-4*TK_PERM[i] -: 4];
      end
      k = nk;
    end
    return k;
  endfunction

  // One full cipher round on a block
  function automatic block_t sk64_round(block_t blk, rkey_t rk, rconst_t rc);
    cell_t  s [16];
    cell_t  t [16];
    block_t res;
    for (int i = 0; i < 16; i++) begin
      s[i] = SBOX[blk[BLOCK_W-1-4*i -: 4]];
    end
    s[0] = s[0] ^ rc[3:0];
    s[4] = s[4] ^ {2'b00, rc[5:4]};
    s[8] = s[8] ^ CELL8_CONST;
    for (int i = 0; i < 8; i++) begin
      s[i] = s[i] ^ rk[RK_W-1-4*i -: 4];
    end
    // Rotate rows right by the row number
    for (int i = 0; i < 4; i++) begin
      t[i]      = s[i];
      t[i + 4]  = s[((i + 3) & 3) + 4];
      t[i + 8]  = s[((i + 2) & 3) + 8];
      t[i + 12] = s[((i + 1) & 3) + 12];
    end
    // Binary column mixing
    for (int i = 0; i < 4; i++) begin
      s[i]      = t[i] ^ t[i + 8] ^ t[i + 12];
      s[i + 4]  = t[i];
      s[i + 8]  = t[i + 4] ^ t[i + 8];
      s[i + 12] = t[i] ^ t[i + 8];
    end
    for (int i = 0; i < 16; i++) begin
      res[BLOCK_W-1-4*i -: 4] = s[i];
    end
    return res;
  endfunction

endpackage

// ----- sv/sk64_round_stage.sv -----
// One pipeline stage: applies a cipher round or passes the block through
module sk64_round_stage
  import sk64_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_vld,
  input  block_t  in_blk,
  input  logic    round_en,
  input  rkey_t   round_key,
  input  rconst_t round_const,
  output logic    out_vld,
  output block_t  out_blk
);

  logic   vld_r;
  logic   vld_nxt;
  block_t blk_r;
  block_t blk_nxt;

  // Compute the round, or bypass once the configured count is reached
  always_comb begin
    vld_nxt = in_vld;
    blk_nxt = round_en ? sk64_round(in_blk, round_key, round_const) : in_blk;
  end

  // Advance the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture the block on every transfer
  always_ff @(posedge clk) begin
    if (vld_nxt) begin
      blk_r <= blk_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_blk = blk_r;

endmodule

// ----- sv/skinny64_block_encrypt_core.sv -----
// Top level of the SKINNY-64-64 encrypt core: configuration and 32-stage round pipeline
//
//  channel | ports                                   | transfer
//  --------+-----------------------------------------+--------------------------------
//  input   | start, busy, in_plaintext               | start high, busy low
//  result  | out_valid, out_ciphertext               | out_valid high, one cycle
//  config  | cfg_valid, cfg_ready, cfg_index,        | cfg_valid and cfg_ready high
//          | cfg_wdata                               |
//
// One round per register stage, 32 stages; a block enters every cycle and its
// result is registered in each stage in turn. Stages past the configured round count
// pass the block through unchanged. busy is always low and nothing stalls; the
// result strobe cannot be held off. Reset (synchronous, active low) empties the
// pipeline, clears the key and sets the round count to 32.
module skinny64_block_encrypt_core
  import sk64_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  block_t               in_plaintext,
  output logic                 out_valid,
  output block_t               out_ciphertext,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  block_t               cfg_wdata
);

  block_t              cipher_key_r;
  logic [RCOUNT_W-1:0] round_count_r;
  logic [RCOUNT_W-1:0] rounds_sat;
  logic                in_accept;

  logic   stg_vld [MAX_ROUNDS+1];
  block_t stg_blk [MAX_ROUNDS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  // Hold configuration registers; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r  <= '0;
      round_count_r <= ROUND_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CIPHER_KEY:  cipher_key_r  <= cfg_wdata;
        REG_ROUND_COUNT: round_count_r <= cfg_wdata[RCOUNT_W-1:0];
        default:         ;
      endcase
    end
  end

  // Saturate the round count at the pipeline depth
  assign rounds_sat = (round_count_r > RCOUNT_W'(MAX_ROUNDS)) ?
                      RCOUNT_W'(MAX_ROUNDS) : round_count_r;

  assign stg_vld[0] = in_accept;
  assign stg_blk[0] = in_plaintext;

  // Round pipeline: stage r applies round r with a fixed-permutation key
  for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_stage
    localparam rconst_t RC = sk64_rc(r);
    block_t stage_key;
    logic   stage_en;

    assign stage_key = sk64_key_perm(cipher_key_r, r);
    assign stage_en  = RCOUNT_W'(r) < rounds_sat;

    sk64_round_stage u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .in_vld      (stg_vld[r]),
      .in_blk      (stg_blk[r]),
      .round_en    (stage_en),
      .round_key   (stage_key[BLOCK_W-1 -: RK_W]),
      .round_const (RC),
      .out_vld     (stg_vld[r+1]),
      .out_blk     (stg_blk[r+1])
    );
  end

  assign out_valid      = stg_vld[MAX_ROUNDS];
  assign out_ciphertext = stg_blk[MAX_ROUNDS];

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the SKINNY-64-64 encrypt core with a cell-level predictor
`timescale 1ns / 1ps

package skinny_check_pkg;
  import sk64_pkg::*;

  // S-box and tweakey cell permutation, cell 0 being the top nibble
  localparam logic [3:0] CELL_SUB [16] = '{
    4'hc, 4'h6, 4'h9, 4'h0, 4'h1, 4'ha, 4'h2, 4'hb,
    4'h3, 4'h8, 4'h5, 4'hd, 4'h4, 4'he, 4'h7, 4'hf
  };
  localparam int KEY_SHUFFLE [16] = '{9, 15, 8, 13, 10, 14, 12, 11, 0, 1, 2, 3, 4, 5, 6, 7};
  localparam logic [3:0] CELL8_XOR = 4'h2;

  // Mirror of the two registers plus the ciphertexts still owed by the core
  class block_tracker;
    block_t     key_reg;
    logic [5:0] rounds_reg;
    block_t     ct_expected [$];

    function new();
      key_reg    = '0;
      rounds_reg = 6'd32;
    endfunction

    // Apply a register write; unknown indexes leave both registers alone
    function void apply_write(logic [CFG_IDX_W-1:0] idx, block_t data);
      if (idx == REG_CIPHER_KEY) begin
        key_reg = data;
      end else if (idx == REG_ROUND_COUNT) begin
        rounds_reg = data[5:0];
      end
    endfunction

    function block_t encrypt_block(block_t pt);
      logic [3:0] st  [16];
      logic [3:0] tmp [16];
      logic [3:0] rk  [16];
      logic [3:0] nrk [16];
      logic [5:0] rc;
      int         nr;
      block_t     ct;
      // Saturate the round count at the pipeline depth
      nr = (rounds_reg > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_reg);
      for (int i = 0; i < 16; i++) begin
        st[i] = pt[BLOCK_W-1-4*i -: 4];
        rk[i] = key_reg[BLOCK_W-1-4*i -: 4];
      end
      rc = '0;
      for (int r = 0; r < nr; r++) begin
        rc = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
        for (int i = 0; i < 16; i++) begin
          st[i] = CELL_SUB[st[i]];
        end
        st[0] = st[0] ^ rc[3:0];
        st[4] = st[4] ^ {2'b00, rc[5:4]};
        st[8] = st[8] ^ CELL8_XOR;
        for (int i = 0; i < 8; i++) begin
          st[i] = st[i] ^ rk[i];
        end
        // Rotate row n right by n cells
        for (int i = 0; i < 4; i++) begin
          tmp[i]      = st[i];
          tmp[i + 4]  = st[((i + 3) % 4) + 4];
          tmp[i + 8]  = st[((i + 2) % 4) + 8];
          tmp[i + 12] = st[((i + 1) % 4) + 12];
        end
        // Mix each column
        for (int i = 0; i < 4; i++) begin
          st[i]      = tmp[i] ^ tmp[i + 8] ^ tmp[i + 12];
          st[i + 4]  = tmp[i];
          st[i + 8]  = tmp[i + 4] ^ tmp[i + 8];
          st[i + 12] = tmp[i] ^ tmp[i + 8];
        end
        for (int i = 0; i < 16; i++) begin
          nrk[i] = rk[KEY_SHUFFLE[i]];
        end
        rk = nrk;
      end
      for (int i = 0; i < 16; i++) begin
        ct[BLOCK_W-1-4*i -: 4] = st[i];
      end
      return ct;
    endfunction

    function void note_plaintext(block_t pt);
      ct_expected.push_back(encrypt_block(pt));
    endfunction

    // Compare against the oldest owed ciphertext; returns 0 with a reason on failure
    function bit check_ciphertext(block_t got, output string why);
      block_t want;
      why = "";
      if (ct_expected.size() == 0) begin
        why = $sformatf("unexpected ciphertext %h", got);
        return 1'b0;
      end
      want = ct_expected.pop_front();
      if (got !== want) begin
        why = $sformatf("ciphertext got %h want %h", got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int owed();
      return ct_expected.size();
    endfunction
  endclass

endpackage

module tb;
  import sk64_pkg::*;
  import skinny_check_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 85;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  block_t               in_plaintext;
  logic                 out_valid;
  block_t               out_ciphertext;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  block_t               cfg_wdata;

  block_tracker tracker = new();
  int           err_count;
  int           idle_cycles;

  skinny64_block_encrypt_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_plaintext   (in_plaintext),
    .out_valid      (out_valid),
    .out_ciphertext (out_ciphertext),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(string why);
    if (err_count < 50) begin
      $display("MISMATCH at %0t: %s", $time, why);
    end
    err_count++;
  endtask

  // Watch every transfer at the rising edge
  always @(posedge clk) begin
    string why;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        tracker.apply_write(cfg_index, cfg_wdata);
      end
      if (start && !busy) begin
        tracker.note_plaintext(in_plaintext);
      end
      if (out_valid) begin
        if (!tracker.check_ciphertext(out_ciphertext, why)) begin
          report_mismatch(why);
        end
      end
    end
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TIMEOUT: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one block after an optional idle burst; leave start high on return
  task automatic send_block(block_t pt, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    in_plaintext <= pt;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, block_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop start and hold until every owed ciphertext has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk);
  endtask

  function automatic block_t rand_block();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap(bit idle_on);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      return $urandom_range(1, 12);
    end
    return 0;
  endfunction

  initial begin
    block_t     pt;
    block_t     wd;
    logic [5:0] nr;
    bit         idle_on;

    err_count    = 0;
    idle_cycles  = 0;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_plaintext <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_CIPHER_KEY;
    cfg_wdata    <= '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: zero key, full 32 rounds
    send_block('0, 0);
    send_block('1, 0);
    drain();

    // Single round with an all-ones key; upper write bits must be masked off
    write_reg(REG_CIPHER_KEY, '1);
    write_reg(REG_ROUND_COUNT, 64'hffff_ffff_ffff_ffc1);
    send_block('0, 0);
    send_block('1, 0);
    send_block(64'h0123_4567_89ab_cdef, 2);
    drain();

    // Zero rounds pass the block straight through
    write_reg(REG_ROUND_COUNT, 64'h0);
    send_block(64'hfedc_ba98_7654_3210, 0);
    send_block('1, 0);
    drain();

    // Counts above the maximum saturate
    write_reg(REG_ROUND_COUNT, 64'd33);
    send_block(64'h0123_4567_89ab_cdef, 0);
    send_block('0, 0);
    drain();
    write_reg(REG_ROUND_COUNT, 64'd63);
    send_block(64'h8000_0000_0000_0001, 0);
    send_block('1, 1);
    drain();

    // Published vector, full rounds
    write_reg(REG_CIPHER_KEY, 64'hf526_9826_fc68_1238);
    write_reg(REG_ROUND_COUNT, 64'd32);
    send_block(64'h0603_4f95_7724_d19d, 0);
    drain();

    // Writes to unused indexes are dropped
    write_reg(CFG_IDX_SPARE2, '1);
    write_reg(CFG_IDX_SPARE3, 64'h5a5a_a5a5_3c3c_c3c3);
    send_block(64'h0603_4f95_7724_d19d, 0);
    send_block(rand_block(), 0);
    drain();

    // Random phases, each with fresh settings; the last one without idling
    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
        0:       wd = '0;
        1:       wd = '1;
        default: wd = rand_block();
      endcase
      write_reg(REG_CIPHER_KEY, wd);
      case ($urandom_range(0, 9))
        0:       nr = 6'd0;
        1:       nr = 6'd32;
        2:       nr = 6'($urandom_range(33, 63));
        3:       nr = 6'd1;
        default: nr = 6'($urandom_range(1, 32));
      endcase
      wd = rand_block();
      write_reg(REG_ROUND_COUNT, {wd[BLOCK_W-1:6], nr});
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE2 : CFG_IDX_SPARE3, rand_block());
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 31))
          0:       pt = '0;
          1:       pt = '1;
          default: pt = rand_block();
        endcase
        send_block(pt, pick_gap(idle_on));
      end
      drain();
    end

    // Let any stray strobe show up before closing
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.owed() != 0) begin
      report_mismatch($sformatf("%0d ciphertexts never arrived", tracker.owed()));
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- skinny64_block_encrypt_core.f -----
sv/sk64_pkg.sv
sv/sk64_round_stage.sv
sv/skinny64_block_encrypt_core.sv
sim/tb.sv
